// ----- sv/kvtl_pkg.sv -----
// kvtl_pkg: shared types and constants for the linear-search key/value table.
// Request/response word structs, op codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package kvtl_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEFAULT = 256;
   localparam int KEY_BITS_DEFAULT = 64;

   // Fixed field widths of the request and response words
   localparam int OP_W    = 2;
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 9;

   // Op codes; the fourth code is unused and does nothing
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Lookup miss answer
   localparam logic signed [VALUE_W-1:0] VALUE_MISS = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [KEY_W-1:0]          lookup_key;
      logic signed [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic                      success;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_RESPOND
   } state_type;

   // Source of the read_value field of a response
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_MISS,
      RES_VALUE
   } res_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        load_req;    // latch request word, restart scan
      logic        step;        // issue next table read
      logic        shift_start; // begin closing the gap after the hit
      logic        shift_wr;    // write back shifted entries
      logic        write_hit;   // overwrite value of the hit entry
      logic        append;      // write new entry at the end, count up
      logic        dec_count;   // count down after a remove
      logic        res_load;    // capture result
      res_sel_type res_sel;
      logic        res_ok;
      logic        rsp_load;    // move result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;       // latched op
      logic            hit;      // compared entry matches the key
      logic            drained;  // no read in flight, none left to issue
      logic            full;     // table holds CAPACITY entries
      logic            out_free; // output register can take a word
   } sts_type;

endpackage

`default_nettype wire

// ----- sv/kvtl_ram.sv -----
// kvtl_ram: generic single-port-write, single-port-read RAM with registered read.
// Used for the entry store of the table. No dependencies.
`default_nettype none

module kvtl_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/kvtl_ctrl.sv -----
// kvtl_ctrl: request sequencer of the key/value table.
// Walks each request through search, optional gap shift and response.
// Depends on kvtl_pkg.
`default_nettype none

module kvtl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kvtl_pkg::sts_type sts,
   output kvtl_pkg::cmd_type     cmd
);

   import kvtl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.res_sel = RES_ZERO;
      req_stall = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            if (!(sts.op inside {OP_LOOKUP, OP_INSERT, OP_REMOVE})) begin
               // unused op: no change, plain answer
               cmd.res_load = 1'b1;
               state_in     = ST_RESPOND;
            end else if (sts.hit) begin
               case (sts.op)
                  OP_LOOKUP: begin
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = RES_VALUE;
                     cmd.res_ok   = 1'b1;
                     state_in     = ST_RESPOND;
                  end
                  OP_INSERT: begin
                     cmd.write_hit = 1'b1;
                     cmd.res_load  = 1'b1;
                     cmd.res_ok    = 1'b1;
                     state_in      = ST_RESPOND;
                  end
                  default: begin
                     cmd.shift_start = 1'b1;
                     state_in        = ST_SHIFT;
                  end
               endcase
            end else if (sts.drained) begin
               // key absent
               cmd.res_load = 1'b1;
               state_in     = ST_RESPOND;
               case (sts.op)
                  OP_LOOKUP: begin
                     cmd.res_sel = RES_MISS;
                  end
                  OP_INSERT: begin
                     cmd.append = !sts.full;
                     cmd.res_ok = !sts.full;
                  end
                  default: begin
                     cmd.res_ok = 1'b0;
                  end
               endcase
            end else begin
               cmd.step = 1'b1;
            end
         end

         ST_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (sts.drained) begin
               cmd.dec_count = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_ok    = 1'b1;
               state_in      = ST_RESPOND;
            end else begin
               cmd.step = 1'b1;
            end
         end

         ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/kvtl_dp.sv -----
// kvtl_dp: datapath of the key/value table: request latch, entry count,
// scan counters, entry RAM, key compare, result and output registers.
// Depends on kvtl_pkg and kvtl_ram.
`default_nettype none

module kvtl_dp #(
   parameter int CAPACITY = kvtl_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = kvtl_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kvtl_pkg::req_type req_data,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output kvtl_pkg::rsp_type      rsp_data,
   input  wire kvtl_pkg::cmd_type cmd,
   output kvtl_pkg::sts_type      sts
);

   import kvtl_pkg::*;

   localparam int IW = $clog2(CAPACITY);     // entry index
   localparam int CW = $clog2(CAPACITY + 1); // entry count
   localparam int EW = KEY_BITS + VALUE_W;   // stored entry

   // Latched request word
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [VALUE_W-1:0]  val_ff, val_in;

   // Table count and scan state
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in; // next index to read
   logic [IW-1:0] cmp_ff, cmp_in;     // index of the data at the RAM output
   logic          pend_ff, pend_in;   // RAM output holds a fresh read

   // Result and output word
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic                      res_ok_ff, res_ok_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // RAM ports
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;
   logic          more;

   kvtl_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign more = (issue_ff < count_ff);

   // Request latch
   always_comb begin
      op_in  = op_ff;
      key_in = key_ff;
      val_in = val_ff;
      if (cmd.load_req) begin
         op_in  = req_data.op;
         key_in = req_data.lookup_key[KEY_BITS-1:0];
         val_in = req_data.write_value;
      end
   end

   // Scan and shift counters
   always_comb begin
      issue_in = issue_ff;
      cmp_in   = cmp_ff;
      pend_in  = pend_ff;
      if (cmd.load_req) begin
         issue_in = '0;
         pend_in  = 1'b0;
      end else if (cmd.shift_start) begin
         issue_in = CW'(cmp_ff) + CW'(1);
         pend_in  = 1'b0;
      end else if (cmd.step) begin
         pend_in = more;
         if (more) begin
            issue_in = issue_ff + CW'(1);
            cmp_in   = issue_ff[IW-1:0];
         end
      end else begin
         pend_in = 1'b0;
      end
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
   end

   // RAM write: value update, append, or shifted entry one place down
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmp_ff;
      wr_data = {key_ff, val_ff};
      if (cmd.write_hit) begin
         wr_en = 1'b1;
      end else if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IW-1:0];
      end else if (cmd.shift_wr && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = cmp_ff - IW'(1);
         wr_data = rd_data;
      end
   end

   // Result capture and output register
   always_comb begin
      res_value_in = res_value_ff;
      res_ok_in    = res_ok_ff;
      if (cmd.res_load) begin
         res_ok_in = cmd.res_ok;
         case (cmd.res_sel)
            RES_VALUE: res_value_in = rd_data[VALUE_W-1:0];
            RES_MISS:  res_value_in = VALUE_MISS;
            default:   res_value_in = '0;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.read_value  = res_value_ff;
         rsp_data_in.success     = res_ok_ff;
         rsp_data_in.entry_count = COUNT_W'(count_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      cmp_ff       <= cmp_in;
      res_value_ff <= res_value_in;
      res_ok_ff    <= res_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Status to the controller
   always_comb begin
      sts.op       = op_ff;
      sts.hit      = pend_ff && (rd_data[EW-1:VALUE_W] == key_ff);
      sts.drained  = !pend_ff && !more;
      sts.full     = (count_ff == CW'(CAPACITY));
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/key_value_table_linear.sv -----
// key_value_table_linear: linear-search key/value table; built from kvtl_ctrl, kvtl_dp.
// Each request scans the entries from the first until the key matches or none are left.
// A remove that hits then shifts the later entries.
// One entry is read per cycle; a remove writes each later entry back one place down.
// A new request is taken only once the last result is in the output register; a new word is taken while a
// response waits. Reset clears the entry count; stored entries need no clearing.
`default_nettype none

module key_value_table_linear #(
   parameter int CAPACITY = kvtl_pkg::CAPACITY_DEFAULT,
   parameter int KEY_BITS = kvtl_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kvtl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kvtl_pkg::rsp_type      rsp_data
);

   import kvtl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kvtl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kvtl_dp #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire
